// File: rtl/core/osas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-loop startup sequencer package
// Shared types, register indexes, limits and the ramp step table.
// ----------------------------------------------------------------------------
package osas_pkg;

    localparam int RAMP_TABLE_LEN = 12;
    localparam int IDX_W          = 4;
    localparam int ACC_W          = 24;
    localparam int ANG_W          = 16;
    localparam int STEP_W         = 8;
    localparam int SHIFT_W        = 5;
    localparam int BLEND_W        = 15;
    localparam int CNT_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [IDX_W-1:0] RAMP_LAST = IDX_W'(RAMP_TABLE_LEN - 1);
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_LOCK_TICKS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HANDOVER_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SHIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_OPEN_LOOP  = 3'd5;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]   lock_ticks;
        logic [ACC_W-1:0]   handover_speed;
        logic [CNT_W-1:0]   step_interval;
        logic [SHIFT_W-1:0] angle_shift;
        logic [BLEND_W-1:0] blend_step;
        logic               hold_open_loop;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] lock_count;
        logic [ACC_W-1:0] ramp_accum;
        logic [CNT_W-1:0] tick_count;
        logic [IDX_W-1:0] table_index;
        logic [ANG_W-1:0] open_angle;
        logic [ANG_W-1:0] offset;
        logic             open_mode;
    } state_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle;
        logic                    open_loop;
        logic [ACC_W-1:0]        ramp_speed;
        logic signed [ANG_W-1:0] angle_offset;
    } result_t;

    function automatic logic [STEP_W-1:0] ramp_step(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] val;
        case (idx)
            4'd0:    val = 8'd2;
            4'd1:    val = 8'd3;
            4'd2:    val = 8'd4;
            4'd3:    val = 8'd5;
            4'd4:    val = 8'd6;
            4'd5:    val = 8'd7;
            4'd6:    val = 8'd8;
            4'd7:    val = 8'd10;
            4'd8:    val = 8'd12;
            4'd9:    val = 8'd14;
            default: val = 8'd16;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/core/osas_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one command word per transfer.
// ----------------------------------------------------------------------------
interface osas_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] est_angle;

    modport source (output valid, output op, output est_angle, input ready);
    modport sink (input valid, input op, input est_angle, output ready);
endinterface

// File: rtl/core/osas_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one result word per transfer.
// ----------------------------------------------------------------------------
interface osas_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle;
    logic               open_loop;
    logic [23:0]        ramp_speed;
    logic signed [15:0] angle_offset;

    modport source (output valid, output angle, output open_loop, output ramp_speed,
                    output angle_offset, input ready);
    modport sink (input valid, input angle, input open_loop, input ramp_speed,
                  input angle_offset, output ready);
endinterface

// File: rtl/core/osas_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Decodes the write port into the six startup control registers.
// ----------------------------------------------------------------------------
module osas_cfg
    import osas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_ticks     <= 16'd4000;
            cfg_reg.handover_speed <= 24'd100000;
            cfg_reg.step_interval  <= 16'd20000;
            cfg_reg.angle_shift    <= 5'd8;
            cfg_reg.blend_step     <= 15'd9;
            cfg_reg.hold_open_loop <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOCK_TICKS:     cfg_reg.lock_ticks     <= cfg_data[CNT_W-1:0];
                REG_HANDOVER_SPEED: cfg_reg.handover_speed <= cfg_data[ACC_W-1:0];
                REG_STEP_INTERVAL:  cfg_reg.step_interval  <= cfg_data[CNT_W-1:0];
                REG_ANGLE_SHIFT:    cfg_reg.angle_shift    <= cfg_data[SHIFT_W-1:0];
                REG_BLEND_STEP:     cfg_reg.blend_step     <= cfg_data[BLEND_W-1:0];
                REG_HOLD_OPEN_LOOP: cfg_reg.hold_open_loop <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/osas_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Startup step logic
// Computes the next sequencer state and the result word for one tick or restart.
// ----------------------------------------------------------------------------
module osas_step
    import osas_pkg::*;
(
    input  state_t                  st,
    input  cfg_t                    cfg,
    input  logic                    op,
    input  logic signed [ANG_W-1:0] est_angle,
    output state_t                  st_next,
    output result_t                 res
);

    logic [CNT_W-1:0]          tick_inc;
    logic [IDX_W-1:0]          idx_next;
    logic [CNT_W-1:0]          tick_next;
    logic [ACC_W:0]            acc_sum;
    logic [ACC_W-1:0]          acc_ramp;
    logic [ACC_W-1:0]          acc_next;
    logic [ACC_W-1:0]          acc_shifted;
    logic [ANG_W-1:0]          ang_inc;
    logic                      do_lock;
    logic                      do_ramp;
    logic signed [ANG_W:0]     off_ext;
    logic [ANG_W:0]            off_mag;
    logic signed [ANG_W:0]     off_adj;
    logic [ANG_W-1:0]          offset_decay;
    logic [ANG_W-1:0]          offset_switch;

    always_comb
    begin
        tick_inc  = st.tick_count + 16'd1;
        tick_next = st.tick_count;
        idx_next  = st.table_index;
        if (st.table_index < RAMP_LAST)
        begin
            tick_next = tick_inc;
            if (tick_inc == cfg.step_interval)
            begin
                tick_next = '0;
                idx_next  = st.table_index + 4'd1;
            end
        end
        acc_sum  = {1'b0, st.ramp_accum} + {{(ACC_W + 1 - STEP_W){1'b0}}, ramp_step(idx_next)};
        acc_ramp = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    end

    assign do_lock = st.lock_count < cfg.lock_ticks;
    assign do_ramp = !do_lock && (st.ramp_accum < cfg.handover_speed);

    assign acc_next    = do_ramp ? acc_ramp : st.ramp_accum;
    assign acc_shifted = (cfg.angle_shift < 5'd24) ? (acc_next >> cfg.angle_shift) : '0;
    assign ang_inc     = acc_shifted[ANG_W-1:0];

    assign offset_switch = st.open_angle - est_angle;

    always_comb
    begin
        off_ext = {st.offset[ANG_W-1], st.offset};
        off_mag = off_ext[ANG_W] ? 17'(-off_ext) : 17'(off_ext);
        off_adj = off_ext;
        if (off_mag > {2'b00, cfg.blend_step})
        begin
            if (off_ext[ANG_W])
                off_adj = off_ext + $signed({2'b00, cfg.blend_step});
            else
                off_adj = off_ext - $signed({2'b00, cfg.blend_step});
        end
        offset_decay = off_adj[ANG_W-1:0];
    end

    always_comb
    begin
        st_next = st;
        res.angle = st.open_angle;
        if (op == OP_RESTART)
        begin
            st_next.lock_count  = '0;
            st_next.ramp_accum  = '0;
            st_next.tick_count  = '0;
            st_next.table_index = '0;
            st_next.open_mode   = 1'b1;
            res.angle           = st.open_angle;
        end
        else if (st.open_mode)
        begin
            if (do_lock)
            begin
                st_next.lock_count = st.lock_count + 16'd1;
            end
            else if (do_ramp)
            begin
                st_next.tick_count  = tick_next;
                st_next.table_index = idx_next;
                st_next.ramp_accum  = acc_ramp;
            end
            else
            begin
                st_next.open_mode = cfg.hold_open_loop;
                st_next.offset    = offset_switch;
            end
            st_next.open_angle = st.open_angle + ang_inc;
            if (st_next.open_mode)
                res.angle = st_next.open_angle;
            else
                res.angle = est_angle + st_next.offset;
        end
        else
        begin
            st_next.offset = offset_decay;
            res.angle      = est_angle + offset_decay;
        end
        res.open_loop    = st_next.open_mode;
        res.ramp_speed   = st_next.ramp_accum;
        res.angle_offset = st_next.offset;
    end

endmodule

// File: rtl/core/open_loop_startup_angle_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-loop startup angle sequencer
// Aligns, ramps and hands over the commutation angle to the estimator.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle and returns one result word for
// each, in order. A word is held in an input register, from which the step
// logic updates the sequencer state and loads the result register when the
// result register is empty or being taken. Back pressure on the output holds
// the result register; the input register still takes a word while it is
// empty, so the input stalls once both registers are full. With the output
// always ready the block sustains one word per cycle.
// Configuration writes take effect in the cycle after the write and should
// only be made while no word is in flight.
// ----------------------------------------------------------------------------
module open_loop_startup_angle_sequencer_core
    import osas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    osas_in_if.sink               in_ch,
    osas_out_if.source            out_ch
);

    cfg_t                    cfg;
    state_t                  state_reg;
    state_t                  state_next;
    result_t                 res_next;
    result_t                 res_reg;
    logic                    s1_valid_reg;
    logic                    s1_op_reg;
    logic signed [ANG_W-1:0] s1_est_reg;
    logic                    out_valid_reg;
    logic                    advance;
    logic                    in_ready;

    osas_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    osas_step u_step (
        .st        (state_reg),
        .cfg       (cfg),
        .op        (s1_op_reg),
        .est_angle (s1_est_reg),
        .st_next   (state_next),
        .res       (res_next)
    );

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ready    = !s1_valid_reg || advance;
    assign in_ch.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{open_mode: 1'b1, default: '0};
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_ch.valid;
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                    state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
        begin
            s1_op_reg  <= in_ch.op;
            s1_est_reg <= in_ch.est_angle;
        end
        if (advance && s1_valid_reg)
            res_reg <= res_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.angle        = res_reg.angle;
    assign out_ch.open_loop    = res_reg.open_loop;
    assign out_ch.ramp_speed   = res_reg.ramp_speed;
    assign out_ch.angle_offset = res_reg.angle_offset;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-loop startup angle sequencer testbench
// Drives control ticks and restarts through the input channel, predicts every
// result word from a behavioral copy of the sequencer and compares each field
// of the words that come back. A short directed table covers reset, register
// extremes, the ramp table end and the hand-over; random phases follow.
// ----------------------------------------------------------------------------
module testbench;
    import osas_pkg::*;

    localparam int DIRECTED_ROWS = 34;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 130;

    localparam logic [7:0] SPEED_STEP [16] = '{
        8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd10,
        8'd12, 8'd14, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16
    };

    typedef enum logic {ROW_WORD, ROW_SETTING} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic                  op;
        logic [ANG_W-1:0]      est;
        logic                  typed;
        result_t               want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    osas_in_if  in_ch ();
    osas_out_if out_ch ();

    open_loop_startup_angle_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #2 clk = ~clk;

    logic [CNT_W-1:0]   cfg_lock_ticks;
    logic [ACC_W-1:0]   cfg_handover_speed;
    logic [CNT_W-1:0]   cfg_step_interval;
    logic [SHIFT_W-1:0] cfg_angle_shift;
    logic [BLEND_W-1:0] cfg_blend_step;
    logic               cfg_hold;

    logic [CNT_W-1:0] seq_lock_count;
    logic [ACC_W-1:0] seq_accum;
    logic [CNT_W-1:0] seq_ticks;
    logic [IDX_W-1:0] seq_index;
    logic [ANG_W-1:0] seq_open_angle;
    logic [ANG_W-1:0] seq_offset;
    logic             seq_open_mode;

    result_t   due_words [$];
    stim_row_t directed [DIRECTED_ROWS];
    int        faults = 0;
    int        words_sent = 0;

    function automatic stim_row_t word_row(input logic op, input logic [ANG_W-1:0] est);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.op = op;
        r.est = est;
        return r;
    endfunction

    function automatic stim_row_t checked_row(input logic op, input logic [ANG_W-1:0] est,
                                              input logic [ANG_W-1:0] angle,
                                              input logic open_loop,
                                              input logic [ACC_W-1:0] speed,
                                              input logic [ANG_W-1:0] offset);
        stim_row_t r;
        r = word_row(op, est);
        r.typed = 1'b1;
        r.want.angle = angle;
        r.want.open_loop = open_loop;
        r.want.ramp_speed = speed;
        r.want.angle_offset = offset;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.kind = ROW_SETTING;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    task automatic advance_sequencer(input logic op, input logic [ANG_W-1:0] est,
                                     output result_t res);
        logic [ACC_W:0]   sum;
        logic [ACC_W-1:0] inc;
        int               off;
        int               mag;
        if (op == OP_RESTART) begin
            seq_lock_count = '0;
            seq_accum = '0;
            seq_ticks = '0;
            seq_index = '0;
            seq_open_mode = 1'b1;
            res.angle = seq_open_angle;
        end
        else if (seq_open_mode) begin
            if (seq_lock_count < cfg_lock_ticks) begin
                seq_lock_count = seq_lock_count + 1'b1;
            end
            else if (seq_accum < cfg_handover_speed) begin
                if (seq_index < RAMP_LAST) begin
                    seq_ticks = seq_ticks + 1'b1;
                    if (seq_ticks == cfg_step_interval) begin
                        seq_ticks = '0;
                        seq_index = seq_index + 1'b1;
                    end
                end
                sum = {1'b0, seq_accum} + SPEED_STEP[seq_index];
                seq_accum = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
            end
            else begin
                if (!cfg_hold) begin
                    seq_open_mode = 1'b0;
                end
                seq_offset = seq_open_angle - est;
            end
            inc = (cfg_angle_shift < 5'd24) ? (seq_accum >> cfg_angle_shift) : '0;
            seq_open_angle = seq_open_angle + inc[ANG_W-1:0];
            res.angle = seq_open_mode ? seq_open_angle : est + seq_offset;
        end
        else begin
            off = int'($signed(seq_offset));
            mag = (off < 0) ? -off : off;
            if (mag > int'(cfg_blend_step)) begin
                off = (off < 0) ? off + int'(cfg_blend_step) : off - int'(cfg_blend_step);
                seq_offset = off[ANG_W-1:0];
            end
            res.angle = est + seq_offset;
        end
        res.open_loop = seq_open_mode;
        res.ramp_speed = seq_accum;
        res.angle_offset = seq_offset;
    endtask

    task automatic send_word(input logic op, input logic [ANG_W-1:0] est,
                             input logic typed, input result_t want);
        result_t predicted;
        while (!(words_sent >= 400 && words_sent < 700) && $urandom_range(99) < 13) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.est_angle <= est;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
        advance_sequencer(op, est, predicted);
        due_words.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_LOCK_TICKS:     cfg_lock_ticks = value[CNT_W-1:0];
            REG_HANDOVER_SPEED: cfg_handover_speed = value[ACC_W-1:0];
            REG_STEP_INTERVAL:  cfg_step_interval = value[CNT_W-1:0];
            REG_ANGLE_SHIFT:    cfg_angle_shift = value[SHIFT_W-1:0];
            REG_BLEND_STEP:     cfg_blend_step = value[BLEND_W-1:0];
            REG_HOLD_OPEN_LOOP: cfg_hold = value[0];
            default: ;
        endcase
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (due_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin : receiver
        int hold_left;
        int taken;
        bit squeezed;
        hold_left = 0;
        taken = 0;
        squeezed = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                taken++;
            end
            if (!squeezed && taken >= 900) begin
                squeezed = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (taken >= 400 && taken < 700) begin
                out_ch.ready <= 1'b1;
            end
            else begin
                out_ch.ready <= ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge clk) begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.angle = out_ch.angle;
            got.open_loop = out_ch.open_loop;
            got.ramp_speed = out_ch.ramp_speed;
            got.angle_offset = out_ch.angle_offset;
            if (due_words.size() == 0) begin
                $error("result word arrived with none expected");
                faults++;
            end
            else begin
                want = due_words.pop_front();
                if (got.angle !== want.angle) begin
                    $error("angle: expected %0d, got %0d", want.angle, got.angle);
                    faults++;
                end
                if (got.open_loop !== want.open_loop) begin
                    $error("open_loop: expected %0d, got %0d", want.open_loop, got.open_loop);
                    faults++;
                end
                if (got.ramp_speed !== want.ramp_speed) begin
                    $error("ramp_speed: expected %0d, got %0d", want.ramp_speed,
                           got.ramp_speed);
                    faults++;
                end
                if (got.angle_offset !== want.angle_offset) begin
                    $error("angle_offset: expected %0d, got %0d", want.angle_offset,
                           got.angle_offset);
                    faults++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end
            else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0]   lock_v;
        logic [ACC_W-1:0]   end_v;
        logic [CNT_W-1:0]   step_v;
        logic [SHIFT_W-1:0] shift_v;
        logic [BLEND_W-1:0] blend_v;
        logic               hold_v;
        logic               op_v;
        int                 pick;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_TICK;
        in_ch.est_angle = '0;

        cfg_lock_ticks = 16'd4000;
        cfg_handover_speed = 24'd100000;
        cfg_step_interval = 16'd20000;
        cfg_angle_shift = 5'd8;
        cfg_blend_step = 15'd9;
        cfg_hold = 1'b0;
        seq_lock_count = '0;
        seq_accum = '0;
        seq_ticks = '0;
        seq_index = '0;
        seq_open_angle = '0;
        seq_offset = '0;
        seq_open_mode = 1'b1;

        directed = '{
            checked_row(OP_RESTART, 16'h0000, 16'h0000, 1'b1, 24'd0, 16'h0000),
            checked_row(OP_TICK,    16'h7FFF, 16'h0000, 1'b1, 24'd0, 16'h0000),
            checked_row(OP_TICK,    16'h8000, 16'h0000, 1'b1, 24'd0, 16'h0000),
            reg_row(REG_LOCK_TICKS, 24'd0),
            reg_row(REG_HANDOVER_SPEED, 24'd0),
            checked_row(OP_TICK,    16'h8000, 16'h0000, 1'b0, 24'd0, 16'h8000),
            word_row(OP_TICK, 16'h0000),
            reg_row(REG_STEP_INTERVAL, 24'd1),
            reg_row(REG_HANDOVER_SPEED, 24'd120),
            reg_row(REG_ANGLE_SHIFT, 24'd31),
            reg_row(REG_BLEND_STEP, 24'd0),
            word_row(OP_RESTART, 16'h5A5A),
            word_row(OP_TICK, 16'h0001),
            word_row(OP_TICK, 16'hFFFF),
            word_row(OP_TICK, 16'h4000),
            word_row(OP_TICK, 16'hC000),
            word_row(OP_TICK, 16'h00FF),
            word_row(OP_TICK, 16'hFF00),
            word_row(OP_TICK, 16'h2468),
            word_row(OP_TICK, 16'h8001),
            word_row(OP_TICK, 16'h7FFE),
            word_row(OP_TICK, 16'h0F0F),
            word_row(OP_TICK, 16'hF0F0),
            word_row(OP_TICK, 16'h5555),
            word_row(OP_TICK, 16'hAAAA),
            word_row(OP_TICK, 16'h1357),
            word_row(OP_TICK, 16'h3C3C),
            reg_row(REG_HOLD_OPEN_LOOP, 24'd1),
            reg_row(REG_HANDOVER_SPEED, 24'd0),
            reg_row(REG_STEP_INTERVAL, 24'd0),
            reg_row(REG_BLEND_STEP, 24'd32767),
            word_row(OP_RESTART, 16'h0F0F),
            word_row(OP_TICK, 16'h7FFF),
            word_row(OP_TICK, 16'h8000)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].kind == ROW_SETTING) begin
                if (i == 0 || directed[i-1].kind != ROW_SETTING) begin
                    settle();
                end
                write_reg(directed[i].reg_index, directed[i].reg_value);
                if (i == DIRECTED_ROWS - 1 || directed[i+1].kind != ROW_SETTING) begin
                    cfg_we <= 1'b0;
                end
            end
            else begin
                send_word(directed[i].op, directed[i].est, directed[i].typed, directed[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    lock_v = 16'd65535;
                    end_v = 24'd16777199;
                    step_v = 16'd65535;
                    shift_v = 5'd23;
                    blend_v = 15'd32767;
                    hold_v = 1'b1;
                end
                1: begin
                    lock_v = 16'd0;
                    end_v = 24'd0;
                    step_v = 16'd1;
                    shift_v = 5'd0;
                    blend_v = 15'd0;
                    hold_v = 1'b0;
                end
                2: begin
                    lock_v = 16'd5;
                    end_v = 24'd1500;
                    step_v = 16'd0;
                    shift_v = 5'($urandom_range(23));
                    blend_v = 15'($urandom_range(40));
                    hold_v = 1'b0;
                end
                default: begin
                    lock_v = ($urandom_range(99) < 80) ? 16'($urandom_range(40))
                                                       : 16'($urandom_range(200));
                    end_v = ($urandom_range(99) < 90) ? 24'($urandom_range(800))
                                                      : 24'($urandom_range(16777199));
                    pick = $urandom_range(99);
                    if (pick < 70) begin
                        step_v = 16'($urandom_range(8, 1));
                    end
                    else if (pick < 90) begin
                        step_v = 16'($urandom_range(400, 9));
                    end
                    else begin
                        step_v = 16'($urandom_range(65535, 1));
                    end
                    shift_v = ($urandom_range(99) < 85) ? 5'($urandom_range(23))
                                                        : 5'($urandom_range(31, 24));
                    pick = $urandom_range(99);
                    if (pick < 60) begin
                        blend_v = 15'($urandom_range(40));
                    end
                    else if (pick < 90) begin
                        blend_v = 15'($urandom_range(2000));
                    end
                    else begin
                        blend_v = 15'($urandom_range(32767));
                    end
                    hold_v = ($urandom_range(99) < 20);
                end
            endcase
            write_reg(REG_LOCK_TICKS, 24'(lock_v));
            write_reg(REG_HANDOVER_SPEED, end_v);
            write_reg(REG_STEP_INTERVAL, 24'(step_v));
            write_reg(REG_ANGLE_SHIFT, 24'(shift_v));
            write_reg(REG_BLEND_STEP, 24'(blend_v));
            write_reg(REG_HOLD_OPEN_LOOP, 24'(hold_v));
            cfg_we <= 1'b0;
            if (phase < 3 || $urandom_range(99) < 60) begin
                send_word(OP_RESTART, 16'($urandom), 1'b0, '0);
            end
            repeat (PHASE_WORDS) begin
                op_v = ($urandom_range(79) == 0) ? OP_RESTART : OP_TICK;
                send_word(op_v, 16'($urandom), 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (faults == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
